>>> hw/rtl/gct_pkg.sv
// ----------------------------------------------------------------------------
// gct_pkg: shared types and constants of the graph connectivity tracker
// Beat payloads, op codes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gct_pkg;

    localparam int NODE_W       = 10;
    localparam int NODE_COUNT_W = 11;
    localparam int TALLY_W      = 20;
    // wide enough for any effective node count up to the largest table
    localparam int CNT_W        = 17;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;
    localparam logic [TALLY_W-1:0]      TALLY_TOP        = 20'hFFFFF;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_CONNECT = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } in_item_t;

    typedef struct packed {
        logic               connected;
        logic               out_of_range;
        logic [TALLY_W-1:0] yes_total;
        logic [TALLY_W-1:0] no_total;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WALK_A,
        ST_WALK_B,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/graph_connectivity_tracker_top.sv
// ----------------------------------------------------------------------------
// graph_connectivity_tracker_top: dynamic graph connectivity over a parent table
// Union-find forest in one RAM; connect links roots, query compares roots.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | in_item_t  (op, node_a, node_b)
//  m_      | out       | m_valid/m_ready  | out_item_t (connected, out_of_range,
//          |           |                  |             yes_total, no_total)
//  cfg_    | in        | cfg_we           | cfg_wdata = node_count
//
//  Connect/query: one RAM read per parent-chain step, walking from node_a and
//  then from node_b; out-of-range and unused ops skip both walks.
//  Clear: one parent entry rewritten per cycle.
//  After reset the same sweep runs over every entry before s_ready rises.
//  A result waits in the output register; the next beat is taken meanwhile and
//  only its completion stalls on m_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_connectivity_tracker_top
    import gct_pkg::*;
#(
    parameter int MAX_NODES = 1024
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output      logic                    s_ready,
    input  wire in_item_t                s_data,
    output      logic                    m_valid,
    input  wire logic                    m_ready,
    output      out_item_t               m_data,
    input  wire logic                    cfg_we,
    input  wire logic [NODE_COUNT_W-1:0] cfg_wdata
);

    localparam int NW = $clog2(MAX_NODES);
    localparam logic [NW-1:0]    LAST_IDX = NW'(MAX_NODES - 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_NODES);

    state_t                  state_reg, state_next;
    in_item_t                item_reg, item_next;
    logic [NW-1:0]           x_reg, x_next;
    logic [NW-1:0]           ra_reg, ra_next;
    logic [NW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic                    conn_reg, conn_next;
    logic                    oor_reg, oor_next;
    logic                    init_reg, init_next;
    logic [TALLY_W-1:0]      yes_reg, yes_next;
    logic [TALLY_W-1:0]      no_reg, no_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;
    logic [NODE_COUNT_W-1:0] node_count_reg;

    logic          ram_we;
    logic [NW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;
    logic          load_out;

    logic [CNT_W-1:0] eff_count;
    logic             oor_in;
    logic [NW-1:0]    a_idx, b_idx;

    gct_ram #(
        .WIDTH(NW),
        .DEPTH(MAX_NODES)
    ) u_parent_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RESET;
        end else if (cfg_we) begin
            node_count_reg <= cfg_wdata;
        end
    end

    always_comb begin
        eff_count = (CNT_W'(node_count_reg) > MAX_CNT) ? MAX_CNT : CNT_W'(node_count_reg);
        oor_in    = (CNT_W'(s_data.node_a) >= eff_count) ||
                    (CNT_W'(s_data.node_b) >= eff_count);
        // in-range indices are below MAX_NODES, so the resize loses nothing
        a_idx     = NW'(s_data.node_a);
        b_idx     = NW'(item_reg.node_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            init_reg    <= 1'b1;
            yes_reg     <= '0;
            no_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            init_reg    <= init_next;
            yes_reg     <= yes_next;
            no_reg      <= no_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        x_reg      <= x_next;
        ra_reg     <= ra_next;
        conn_reg   <= conn_next;
        oor_reg    <= oor_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        x_next       = x_reg;
        ra_next      = ra_reg;
        clr_cnt_next = clr_cnt_reg;
        conn_next    = conn_reg;
        oor_next     = oor_reg;
        init_next    = init_reg;
        yes_next     = yes_reg;
        no_next      = no_reg;
        m_data_next  = m_data_reg;
        load_out     = 1'b0;
        s_ready      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = clr_cnt_reg;
        ram_wdata    = clr_cnt_reg;
        ram_raddr    = x_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                ram_raddr = a_idx;
                if (s_valid) begin
                    item_next = s_data;
                    x_next    = a_idx;
                    oor_next  = 1'b0;
                    conn_next = 1'b0;
                    if (s_data.op == OP_CLEAR) begin
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end else if (s_data.op == OP_CONNECT || s_data.op == OP_QUERY) begin
                        if (oor_in) begin
                            oor_next   = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_WALK_A;
                        end
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (clr_cnt_reg == LAST_IDX) begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_WALK_A: begin
                if (ram_rdata == x_reg) begin
                    ra_next    = x_reg;
                    x_next     = b_idx;
                    ram_raddr  = b_idx;
                    state_next = ST_WALK_B;
                end else begin
                    x_next    = ram_rdata;
                    ram_raddr = ram_rdata;
                end
            end
            ST_WALK_B: begin
                if (ram_rdata == x_reg) begin
                    // x_reg is root b; hang root a beneath it
                    if (item_reg.op == OP_CONNECT && ra_reg != x_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = ra_reg;
                        ram_wdata = x_reg;
                    end
                    conn_next  = (item_reg.op == OP_QUERY) && (ra_reg == x_reg);
                    state_next = ST_DONE;
                end else begin
                    x_next    = ram_rdata;
                    ram_raddr = ram_rdata;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out = 1'b1;
                    if (item_reg.op == OP_CLEAR) begin
                        yes_next = '0;
                        no_next  = '0;
                    end else if (item_reg.op == OP_QUERY && !oor_reg) begin
                        if (conn_reg && yes_reg != TALLY_TOP) begin
                            yes_next = yes_reg + 1'b1;
                        end
                        if (!conn_reg && no_reg != TALLY_TOP) begin
                            no_next = no_reg + 1'b1;
                        end
                    end
                    m_data_next.connected    = conn_reg;
                    m_data_next.out_of_range = oor_reg;
                    m_data_next.yes_total    = yes_next;
                    m_data_next.no_total     = no_next;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = load_out | (m_valid_reg & ~m_ready);
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_no_result_during_init: assert property (@(posedge aclk) disable iff (!aresetn)
        init_reg |-> !m_valid_reg)
        else $error("result beat during the reset sweep");

    a_link_not_self: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == ST_WALK_B) |-> (ram_waddr != ram_wdata))
        else $error("link would make a root its own child");

    a_oor_not_connected: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> !(m_data_reg.connected && m_data_reg.out_of_range))
        else $error("out-of-range result flagged as connected");

    a_clear_zeroes_tallies: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && item_reg.op == OP_CLEAR) |=>
            (m_data_reg.yes_total == '0 && m_data_reg.no_total == '0))
        else $error("clear result carries non-zero tallies");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/gct_ram.sv
// ----------------------------------------------------------------------------
// gct_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gct_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> test/tb_graph_connectivity_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_connectivity_tracker_top: self-checking bench for the tracker
// Drives clear, connect, query and unused-op beats over several node counts
// and idling patterns. Each beat taken is scored by a union-find mirror, and
// every result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_graph_connectivity_tracker_top;
    import gct_pkg::*;

    localparam int MAX_NODES = 1024;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 1500;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_we = 1'b0;
    logic [NODE_COUNT_W-1:0] cfg_wdata = '0;

    // union-find mirror and tallies
    logic [NODE_W-1:0] comp_parent [MAX_NODES];
    logic [TALLY_W-1:0] yes_tally;
    logic [TALLY_W-1:0] no_tally;
    logic [NODE_COUNT_W-1:0] node_count_cfg;

    in_item_t pending_beats [$];
    out_item_t expected_results [$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned hold_left = 0;
    logic hold_load = 1'b0;

    always #10 aclk = ~aclk;

    graph_connectivity_tracker_top #(
        .MAX_NODES(MAX_NODES)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    function automatic int unsigned root_of(int unsigned x);
        int unsigned steps;
        steps = 0;
        while (x < MAX_NODES && comp_parent[x] != x && steps < MAX_NODES) begin
            x = comp_parent[x];
            steps++;
        end
        return x;
    endfunction

    function automatic void wipe_graph();
        for (int i = 0; i < MAX_NODES; i++) comp_parent[i] = i[NODE_W-1:0];
        yes_tally = '0;
        no_tally = '0;
    endfunction

    function automatic out_item_t track_graph_item(in_item_t it);
        out_item_t r;
        int unsigned lim;
        int unsigned ra;
        int unsigned rb;
        r = '0;
        lim = (node_count_cfg > MAX_NODES) ? MAX_NODES : node_count_cfg;
        case (it.op)
            OP_CLEAR: begin
                wipe_graph();
            end
            OP_CONNECT, OP_QUERY: begin
                if (it.node_a >= lim || it.node_b >= lim) begin
                    r.out_of_range = 1'b1;
                end else begin
                    ra = root_of(it.node_a);
                    rb = root_of(it.node_b);
                    if (it.op == OP_CONNECT) begin
                        if (ra != rb && ra < MAX_NODES) comp_parent[ra] = rb[NODE_W-1:0];
                    end else begin
                        r.connected = (ra == rb);
                        if (r.connected) begin
                            if (yes_tally != TALLY_TOP) yes_tally++;
                        end else begin
                            if (no_tally != TALLY_TOP) no_tally++;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.yes_total = yes_tally;
        r.no_total = no_tally;
        return r;
    endfunction

    // input driver: predicts on each beat taken, then offers the next one
    always @(posedge aclk) begin : drive_inputs
        logic next_valid;
        in_item_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            next_item = s_data;
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(), track_graph_item(s_data));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_beats.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_beats.pop_front();
                next_valid = 1'b1;
            end
            s_valid <= next_valid;
            s_data <= next_item;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) hold_left <= 0;
        else if (hold_load) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic log_fault(input string msg);
        if (mismatch_count < 10) $display("%t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                log_fault($sformatf("unexpected result beat conn=%0b oor=%0b yes=%0d no=%0d",
                          m_data.connected, m_data.out_of_range,
                          m_data.yes_total, m_data.no_total));
            end else begin
                want = expected_results.pop_front();
                if (m_data.connected !== want.connected ||
                    m_data.out_of_range !== want.out_of_range ||
                    m_data.yes_total !== want.yes_total ||
                    m_data.no_total !== want.no_total) begin
                    log_fault($sformatf({"result mismatch: exp conn=%0b oor=%0b yes=%0d no=%0d",
                              " got conn=%0b oor=%0b yes=%0d no=%0d"},
                              want.connected, want.out_of_range, want.yes_total,
                              want.no_total, m_data.connected, m_data.out_of_range,
                              m_data.yes_total, m_data.no_total));
                end
            end
        end
    end

    task automatic push_item(input logic [1:0] op, input int unsigned a, input int unsigned b);
        in_item_t it;
        it.op = op;
        it.node_a = a[NODE_W-1:0];
        it.node_b = b[NODE_W-1:0];
        pending_beats.insert(pending_beats.size(), it);
    endtask

    function automatic int unsigned pick_node(int unsigned eff);
        if (eff == 0 || $urandom_range(99) < 8) return $urandom_range(MAX_NODES - 1);
        return $urandom_range(eff - 1);
    endfunction

    task automatic push_random(input int unsigned eff);
        int unsigned roll;
        int unsigned a;
        int unsigned b;
        logic [1:0] op;
        roll = $urandom_range(99);
        a = pick_node(eff);
        b = ($urandom_range(99) < 10) ? a : pick_node(eff);
        if (roll < 2) op = OP_CLEAR;
        else if (roll < 5) op = OP_UNUSED;
        else if (roll < 47) op = OP_CONNECT;
        else op = OP_QUERY;
        push_item(op, a, b);
    endtask

    // waits until every beat has gone through and its result has come back
    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_node_count(input logic [NODE_COUNT_W-1:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        node_count_cfg = value;
    endtask

    task automatic random_phase(input logic [NODE_COUNT_W-1:0] count, input int unsigned n,
                                input int unsigned send_pct, input int unsigned recv_pct);
        int unsigned eff;
        eff = (count > MAX_NODES) ? MAX_NODES : count;
        write_node_count(count);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) push_random(eff);
        wait_idle();
    endtask

    initial begin
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        wipe_graph();
        node_count_cfg = NODE_COUNT_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // table sweep after reset
        while (s_ready !== 1'b1) @(posedge aclk);

        // directed: self loop, far ends, alternating bit patterns, chains, clear
        write_node_count(11'd1024);
        push_item(OP_QUERY, 0, 0);
        push_item(OP_QUERY, 1023, 0);
        push_item(OP_CONNECT, 0, 1023);
        push_item(OP_QUERY, 1023, 0);
        push_item(OP_CONNECT, 10'h155, 10'h2AA);
        push_item(OP_QUERY, 10'h2AA, 10'h3FF);
        push_item(OP_CONNECT, 1023, 10'h2AA);
        push_item(OP_QUERY, 10'h155, 0);
        push_item(OP_UNUSED, 1023, 1023);
        push_item(OP_CLEAR, 1023, 0);
        push_item(OP_QUERY, 0, 1023);
        wait_idle();

        // zero node count: every index is out of range
        write_node_count(11'd0);
        push_item(OP_QUERY, 0, 0);
        push_item(OP_CONNECT, 0, 0);
        push_item(OP_UNUSED, 0, 0);
        wait_idle();

        // above the table size acts as the full table
        write_node_count(11'd2047);
        push_item(OP_QUERY, 1023, 1023);
        push_item(OP_CONNECT, 1023, 5);
        push_item(OP_QUERY, 5, 1023);
        wait_idle();

        write_node_count(11'd1);
        push_item(OP_QUERY, 0, 0);
        push_item(OP_QUERY, 0, 1);
        push_item(OP_CONNECT, 1, 0);
        wait_idle();

        write_node_count(11'd2);
        push_item(OP_CONNECT, 0, 1);
        push_item(OP_QUERY, 1, 0);
        push_item(OP_QUERY, 2, 0);
        wait_idle();

        // tally saturation needs a million queries and lies beyond this run
        random_phase(11'd16, 150, 0, 0);
        random_phase(11'd1024, 120, 78, 0);
        random_phase(11'd64, 150, 0, 78);
        random_phase(11'd5, 100, 78, 78);
        random_phase(11'd2047, 100, 18, 18);

        // receiver holds off while the sender keeps offering beats
        write_node_count(11'd200);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_load <= 1'b1;
        @(posedge aclk);
        hold_load <= 1'b0;
        repeat (100) push_random(200);
        wait_idle();

        random_phase(11'd1, 40, 18, 18);
        random_phase(11'd1024, 60, 0, 0);

        repeat (20) @(posedge aclk);
        if (expected_results.size() != 0) mismatch_count += expected_results.size();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
